### rtl/tick_task_scheduler_defines.svh
// Assertion macros shared by the tick task scheduler checker.
// Depends on signals named clk and arst_n in the module that uses them.
`ifndef TICK_TASK_SCHEDULER_DEFINES_SVH
`define TICK_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTS_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tick_task_scheduler: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define TTS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tick_task_scheduler: property failed");

`endif

### rtl/tts_pkg.sv
// Package for the tick task scheduler: request and status codes, slot entry type.
// No dependencies.
package tts_pkg;

	// Request codes on the mode field.
	localparam logic [1:0] MODE_ADD  = 2'd0;
	localparam logic [1:0] MODE_DEL  = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;
	localparam logic [1:0] MODE_DISP = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_ADDED      = 3'd0;
	localparam logic [2:0] ST_FULL       = 3'd1;
	localparam logic [2:0] ST_DELETED    = 3'd2;
	localparam logic [2:0] ST_TICKED     = 3'd3;
	localparam logic [2:0] ST_DISPATCHED = 3'd4;
	localparam logic [2:0] ST_IDLE       = 3'd5;

	// Most tasks emitted by one dispatch request.
	localparam int MAX_RESULTS = 8;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS);

	// One slot of the task table as held in the slot memory.
	typedef struct packed {
		logic [7:0]  tag;
		logic [15:0] delay;
		logic [15:0] period;
	} slot_entry_t;

endpackage

### rtl/tts_slot_mem.sv
// Slot memory: simple dual-port table of tag, delay and period per slot.
// Depends on tts_pkg for the entry type. Read data is registered.
module tts_slot_mem #(
	parameter int DEPTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  tts_pkg::slot_entry_t  wr_data,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output tts_pkg::slot_entry_t  rd_data
);
	import tts_pkg::*;

	slot_entry_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/tts_ctrl.sv
// Sequencer of the tick task scheduler: request handling, slot flags and result register.
// Depends on tts_pkg; drives the ports of tts_slot_mem.
module tts_ctrl #(
	parameter int NUM_SLOTS = 8,
	localparam int IW = $clog2(NUM_SLOTS),
	localparam int CW = IW + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [7:0]            task_tag,
	input  logic [15:0]           start_delay,
	input  logic [15:0]           repeat_period,
	input  logic [2:0]            slot,
	output logic                  mem_wr_en,
	output logic [IW-1:0]         mem_wr_addr,
	output tts_pkg::slot_entry_t  mem_wr_data,
	output logic                  mem_rd_en,
	output logic [IW-1:0]         mem_rd_addr,
	input  tts_pkg::slot_entry_t  mem_rd_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            status,
	output logic [2:0]            slot_index,
	output logic [7:0]            tag_out,
	output logic [2:0]            current_slot,
	output logic                  last
);
	import tts_pkg::*;

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_TICK  = 3'd2;
	localparam logic [2:0] S_TEND  = 3'd3;
	localparam logic [2:0] S_DREAD = 3'd4;
	localparam logic [2:0] S_DEMIT = 3'd5;

	logic [2:0]           state_q;
	logic [1:0]           mode_q;
	logic [7:0]           tag_q;
	logic [15:0]          delay_q;
	logic [15:0]          period_q;
	logic [2:0]           slot_q;
	logic [NUM_SLOTS-1:0] used_q;
	logic [NUM_SLOTS-1:0] ready_q;
	logic [2:0]           recent_q;
	logic [CW-1:0]        tk_q;
	logic                 tv_s1;
	logic [IW-1:0]        ti_s1;
	logic [NUM_SLOTS-1:0] pend_q;
	logic [RES_CNT_W-1:0] dcnt_q;
	logic [IW-1:0]        dsel_q;

	logic                 out_valid_q;
	logic [2:0]           status_q;
	logic [2:0]           slot_index_q;
	logic [7:0]           tag_out_q;
	logic [2:0]           current_q;
	logic                 last_q;

	logic                 out_free;
	logic                 free_found;
	logic [IW-1:0]        free_idx;
	logic [IW-1:0]        pend_idx;
	logic [NUM_SLOTS-1:0] del_mask;
	logic [NUM_SLOTS-1:0] dsel_mask;
	logic [NUM_SLOTS-1:0] pend_next;
	logic                 del_in_range;
	logic                 tick_upd;
	logic                 disp_last;
	slot_entry_t          tick_entry;

	logic                 o_load;
	logic [2:0]           o_status;
	logic [2:0]           o_idx;
	logic [7:0]           o_tag;
	logic [2:0]           o_cur;
	logic                 o_last;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// Lowest free slot, lowest pending slot and per-slot decode masks.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		pend_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
			if (pend_q[i]) begin
				pend_idx = IW'(i);
			end
		end
		for (int i = 0; i < NUM_SLOTS; i++) begin
			del_mask[i]  = (int'(slot_q) == i);
			dsel_mask[i] = (dsel_q == IW'(i));
		end
	end

	assign del_in_range = (int'(slot_q) < NUM_SLOTS);
	assign pend_next    = pend_q & ~dsel_mask;
	assign disp_last    = (dcnt_q == RES_CNT_W'(MAX_RESULTS - 1)) || (pend_next == '0);

	// Tick update of the entry read in the previous cycle.
	assign tick_upd = (state_q == S_TICK) && tv_s1 && used_q[ti_s1];
	always_comb begin
		tick_entry = mem_rd_data;
		if (mem_rd_data.delay == 16'd0) begin
			if (mem_rd_data.period != 16'd0) begin
				tick_entry.delay = mem_rd_data.period;
			end
		end else begin
			tick_entry.delay = mem_rd_data.delay - 16'd1;
		end
	end

	// Memory accesses: add writes, tick reads and writes back, dispatch reads.
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = free_idx;
		mem_wr_data = '{tag: tag_q, delay: delay_q, period: period_q};
		mem_rd_en   = 1'b0;
		mem_rd_addr = tk_q[IW-1:0];
		case (state_q)
			S_EXEC: begin
				mem_wr_en = (mode_q == MODE_ADD) && out_free && free_found;
			end
			S_TICK: begin
				mem_wr_en   = tick_upd;
				mem_wr_addr = ti_s1;
				mem_wr_data = tick_entry;
				mem_rd_en   = (tk_q < CW'(NUM_SLOTS));
			end
			S_DREAD: begin
				mem_rd_en   = (pend_q != '0);
				mem_rd_addr = pend_idx;
			end
			default: begin
			end
		endcase
	end

	// Result to load into the output register this cycle.
	always_comb begin
		o_load   = 1'b0;
		o_status = ST_IDLE;
		o_idx    = 3'd0;
		o_tag    = 8'd0;
		o_cur    = recent_q;
		o_last   = 1'b1;
		case (state_q)
			S_EXEC: begin
				if (mode_q == MODE_ADD) begin
					o_load   = out_free;
					o_status = free_found ? ST_ADDED : ST_FULL;
					o_idx    = free_found ? 3'(free_idx) : 3'd0;
				end else if (mode_q == MODE_DEL) begin
					o_load   = out_free;
					o_status = ST_DELETED;
					o_idx    = slot_q;
				end
			end
			S_TEND: begin
				o_load   = out_free;
				o_status = ST_TICKED;
			end
			S_DREAD: begin
				o_load   = out_free && (pend_q == '0);
				o_status = ST_IDLE;
			end
			S_DEMIT: begin
				o_load   = out_free;
				o_status = ST_DISPATCHED;
				o_idx    = 3'(dsel_q);
				o_tag    = mem_rd_data.tag;
				o_cur    = 3'(dsel_q);
				o_last   = disp_last;
			end
			default: begin
			end
		endcase
	end

	// Sequencer, slot flags and scan counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			used_q   <= '0;
			ready_q  <= '0;
			recent_q <= 3'd0;
			tk_q     <= '0;
			tv_s1    <= 1'b0;
			ti_s1    <= '0;
			pend_q   <= '0;
			dcnt_q   <= '0;
			dsel_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (mode_q)
						MODE_ADD: begin
							if (out_free) begin
								if (free_found) begin
									used_q[free_idx]  <= 1'b1;
									ready_q[free_idx] <= 1'b0;
								end
								state_q <= S_IDLE;
							end
						end
						MODE_DEL: begin
							if (out_free) begin
								if (del_in_range) begin
									used_q  <= used_q & ~del_mask;
									ready_q <= ready_q & ~del_mask;
								end
								state_q <= S_IDLE;
							end
						end
						MODE_TICK: begin
							tk_q    <= '0;
							tv_s1   <= 1'b0;
							state_q <= S_TICK;
						end
						default: begin
							pend_q  <= used_q & ready_q;
							dcnt_q  <= '0;
							state_q <= S_DREAD;
						end
					endcase
				end
				S_TICK: begin
					// Read slot tk_q while slot ti_s1 is updated and written back.
					if (tick_upd && (mem_rd_data.delay == 16'd0)) begin
						ready_q[ti_s1] <= 1'b1;
					end
					tv_s1 <= (tk_q < CW'(NUM_SLOTS));
					ti_s1 <= tk_q[IW-1:0];
					if (tk_q == CW'(NUM_SLOTS)) begin
						state_q <= S_TEND;
					end else begin
						tk_q <= tk_q + CW'(1);
					end
				end
				S_TEND: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DREAD: begin
					if (pend_q != '0) begin
						dsel_q  <= pend_idx;
						state_q <= S_DEMIT;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DEMIT: begin
					if (out_free) begin
						ready_q[dsel_q] <= 1'b0;
						if (mem_rd_data.period == 16'd0) begin
							used_q[dsel_q] <= 1'b0;
						end
						recent_q <= 3'(dsel_q);
						pend_q   <= pend_next;
						dcnt_q   <= dcnt_q + RES_CNT_W'(1);
						state_q  <= disp_last ? S_IDLE : S_DREAD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request register, loaded on an input transfer.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q   <= mode;
			tag_q    <= task_tag;
			delay_q  <= start_delay;
			period_q <= repeat_period;
			slot_q   <= slot;
		end
	end

	// Output register: valid flag under reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (o_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (o_load) begin
			status_q     <= o_status;
			slot_index_q <= o_idx;
			tag_out_q    <= o_tag;
			current_q    <= o_cur;
			last_q       <= o_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign slot_index   = slot_index_q;
	assign tag_out      = tag_out_q;
	assign current_slot = current_q;
	assign last         = last_q;

endmodule

### rtl/tick_task_scheduler.sv
// Tick task scheduler: a table of timed task slots driven by add, delete,
// tick and dispatch requests.
//
// Input channel (in_valid/in_ready) carries one request per transfer: mode,
// task_tag, start_delay, repeat_period and slot. Output channel
// (out_valid/out_ready) carries results: status, slot_index, tag_out,
// current_slot and last. Every request gives one result, except dispatch,
// which gives one result per ready task (at most eight); last marks the
// final result of a request.
// Requests are handled one at a time. Add and delete answer from the
// execute state once the output register is free. A tick walks the slot
// memory one slot per cycle, read and write-back overlapped, then answers
// from its end state. A dispatch spends a read state and an emit state per
// emitted task; with nothing ready the read state gives an idle result.
// The final result sits in an output register, so the next request is taken
// while it waits; a stalled receiver holds the block at the next result.
// Reset clears the used and ready flags of every slot and the current slot;
// the slot memory itself needs no clearing.
// Depends on tts_pkg, tts_slot_mem and tts_ctrl.
module tick_task_scheduler #(
	parameter int NUM_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  task_tag,
	input  logic [15:0] start_delay,
	input  logic [15:0] repeat_period,
	input  logic [2:0]  slot,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [2:0]  slot_index,
	output logic [7:0]  tag_out,
	output logic [2:0]  current_slot,
	output logic        last
);
	import tts_pkg::*;

	localparam int IW = $clog2(NUM_SLOTS);

	logic          mem_wr_en;
	logic [IW-1:0] mem_wr_addr;
	slot_entry_t   mem_wr_data;
	logic          mem_rd_en;
	logic [IW-1:0] mem_rd_addr;
	slot_entry_t   mem_rd_data;

	// Slot table storage.
	tts_slot_mem #(
		.DEPTH(NUM_SLOTS)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// Request sequencer and result register.
	tts_ctrl #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.task_tag      (task_tag),
		.start_delay   (start_delay),
		.repeat_period (repeat_period),
		.slot          (slot),
		.mem_wr_en     (mem_wr_en),
		.mem_wr_addr   (mem_wr_addr),
		.mem_wr_data   (mem_wr_data),
		.mem_rd_en     (mem_rd_en),
		.mem_rd_addr   (mem_rd_addr),
		.mem_rd_data   (mem_rd_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.slot_index    (slot_index),
		.tag_out       (tag_out),
		.current_slot  (current_slot),
		.last          (last)
	);

endmodule

### rtl/tts_checker.sv
// Port-level checker for the tick task scheduler, bound to the top level.
// Depends on tts_pkg and the macros in tick_task_scheduler_defines.svh.
`include "tick_task_scheduler_defines.svh"

module tts_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic [2:0] slot_index,
	input logic [7:0] tag_out,
	input logic [2:0] current_slot,
	input logic       last
);
	import tts_pkg::*;

	// A stalled result holds.
	`TTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(slot_index) && $stable(tag_out) && $stable(last))

	// Only a dispatch can give more than one result per request.
	`TTS_ASSERT_IMPL(a_single_last, out_valid && status != ST_DISPATCHED, last)

	// Results without a slot carry zero index and tag.
	`TTS_ASSERT_IMPL(a_zero_fields, out_valid && (status == ST_FULL || status == ST_TICKED || status == ST_IDLE), slot_index == 3'd0 && tag_out == 8'd0)

	// A dispatched slot becomes the current slot.
	`TTS_ASSERT_IMPL(a_dispatch_current, out_valid && status == ST_DISPATCHED, current_slot == slot_index)

	// Status is always one of the defined codes.
	`TTS_ASSERT_IMPL(a_status_range, out_valid, status <= ST_IDLE)

endmodule

bind tick_task_scheduler tts_port_checker u_tts_port_checker (.*);

### verif/tts_checker.sv
// Result checker for the tick task scheduler: tracks the slot table and compares results.
// Watches both channels of the block; depends on tts_pkg for request and status codes.
module tts_checker
	import tts_pkg::*;
#(
	parameter int NUM_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  task_tag,
	input  logic [15:0] start_delay,
	input  logic [15:0] repeat_period,
	input  logic [2:0]  slot,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic [2:0]  slot_index,
	input  logic [7:0]  tag_out,
	input  logic [2:0]  current_slot,
	input  logic        last,
	output int          fail_count,
	output int          results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] slot_index;
		logic [7:0] tag;
		logic [2:0] current;
		logic       last;
	} sched_result_t;

	// Shadow copy of the task table.
	logic        used_tbl   [NUM_SLOTS];
	logic [7:0]  tag_tbl    [NUM_SLOTS];
	logic [15:0] delay_tbl  [NUM_SLOTS];
	logic [15:0] period_tbl [NUM_SLOTS];
	logic        ready_tbl  [NUM_SLOTS];
	logic [2:0]  recent;

	sched_result_t due_results[$];
	sched_result_t want;
	int fails = 0;

	assign fail_count = fails;

	task automatic free_slot(int k);
		used_tbl[k]   = 1'b0;
		tag_tbl[k]    = '0;
		delay_tbl[k]  = '0;
		period_tbl[k] = '0;
		ready_tbl[k]  = 1'b0;
	endtask

	function automatic sched_result_t make_result(logic [2:0] st, logic [2:0] idx,
			logic [7:0] tag, logic fin);
		sched_result_t r;
		r.status     = st;
		r.slot_index = idx;
		r.tag        = tag;
		r.current    = recent;
		r.last       = fin;
		return r;
	endfunction

	// Apply one request to the shadow table and queue the results it causes.
	task automatic schedule_request(logic [1:0] m, logic [7:0] t, logic [15:0] d,
			logic [15:0] p, logic [2:0] s);
		int k;
		int emitted;
		sched_result_t held;
		logic [7:0] run_tag;

		emitted = 0;
		held = '0;
		case (m)
			MODE_ADD: begin
				k = 0;
				while (k < NUM_SLOTS && used_tbl[k])
					k++;
				if (k == NUM_SLOTS) begin
					due_results.push_back(make_result(ST_FULL, 3'd0, 8'd0, 1'b1));
				end else begin
					used_tbl[k]   = 1'b1;
					tag_tbl[k]    = t;
					delay_tbl[k]  = d;
					period_tbl[k] = p;
					ready_tbl[k]  = 1'b0;
					due_results.push_back(make_result(ST_ADDED, 3'(k), 8'd0, 1'b1));
				end
			end
			MODE_DEL: begin
				if (int'(s) < NUM_SLOTS)
					free_slot(int'(s));
				due_results.push_back(make_result(ST_DELETED, s, 8'd0, 1'b1));
			end
			MODE_TICK: begin
				for (k = 0; k < NUM_SLOTS; k++) begin
					if (!used_tbl[k])
						continue;
					if (delay_tbl[k] == 16'd0) begin
						ready_tbl[k] = 1'b1;
						if (period_tbl[k] != 16'd0)
							delay_tbl[k] = period_tbl[k];
					end else begin
						delay_tbl[k] = delay_tbl[k] - 16'd1;
					end
				end
				due_results.push_back(make_result(ST_TICKED, 3'd0, 8'd0, 1'b1));
			end
			MODE_DISP: begin
				// Each result is held back one step so the final one can carry last.
				for (k = 0; k < NUM_SLOTS && emitted < MAX_RESULTS; k++) begin
					if (!(used_tbl[k] && ready_tbl[k]))
						continue;
					run_tag = tag_tbl[k];
					ready_tbl[k] = 1'b0;
					recent = 3'(k);
					if (period_tbl[k] == 16'd0)
						free_slot(k);
					if (emitted != 0)
						due_results.push_back(held);
					held = make_result(ST_DISPATCHED, 3'(k), run_tag, 1'b0);
					emitted++;
				end
				if (emitted == 0) begin
					due_results.push_back(make_result(ST_IDLE, 3'd0, 8'd0, 1'b1));
				end else begin
					held.last = 1'b1;
					due_results.push_back(held);
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
		if (got_val !== exp_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
				got_val);
			fails++;
		end
	endtask

	// Results are matched before the request of the same edge is queued.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SLOTS; k++)
				free_slot(k);
			recent = 3'd0;
			due_results.delete();
			results_owed <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual status %0d slot %0d",
						$time, status, slot_index);
					fails++;
				end else begin
					want = due_results.pop_front();
					check_field("status", 8'(want.status), 8'(status));
					check_field("slot_index", 8'(want.slot_index), 8'(slot_index));
					check_field("tag_out", want.tag, tag_out);
					check_field("current_slot", 8'(want.current), 8'(current_slot));
					check_field("last", 8'(want.last), 8'(last));
				end
			end
			if (in_valid && in_ready)
				schedule_request(mode, task_tag, start_delay, repeat_period, slot);
			results_owed <= due_results.size();
		end
	end

endmodule

### verif/tb_top.sv
// Top of the tick task scheduler testbench: clock, reset, request and result traffic.
// Depends on tts_pkg, tick_task_scheduler and tts_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tts_pkg::*;

	localparam int NUM_SLOTS    = 8;
	localparam int RANDOM_ITEMS = 156;
	localparam int CALM_ITEMS   = 40;
	localparam int LONG_HOLD    = 400;
	localparam int TAIL_CYCLES  = 40;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  tag;
		logic [15:0] delay;
		logic [15:0] period;
		logic [2:0]  slot;
	} sched_request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = MODE_TICK;
	logic [7:0]  task_tag = '0;
	logic [15:0] start_delay = '0;
	logic [15:0] repeat_period = '0;
	logic [2:0]  slot = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [2:0]  slot_index;
	logic [7:0]  tag_out;
	logic [2:0]  current_slot;
	logic        last;
	int          fail_count;
	int          results_owed;
	logic        calm = 1'b0;
	logic        hold_req = 1'b0;

	tick_task_scheduler #(.NUM_SLOTS(NUM_SLOTS)) dut (.*);

	tts_checker #(.NUM_SLOTS(NUM_SLOTS)) sched_chk (.*);

	// Clock, 8 ns period.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("tb_top failed");
		$finish;
	end

	// Result side: random stall bursts, one long hold-off on request, none when calm.
	initial begin : receiver
		bit hold_taken;
		hold_taken = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	function automatic sched_request_t req(logic [1:0] m, logic [7:0] t, logic [15:0] d,
			logic [15:0] p, logic [2:0] s);
		sched_request_t r;
		r.mode   = m;
		r.tag    = t;
		r.delay  = d;
		r.period = p;
		r.slot   = s;
		return r;
	endfunction

	// Tick counts: mostly short, with zero, all-ones and full-range values mixed in.
	function automatic logic [15:0] random_ticks(int zero_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < zero_pct)
			return 16'd0;
		else if (roll < 85)
			return 16'($urandom_range(1, 5));
		else if (roll < 92)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	function automatic sched_request_t random_request();
		sched_request_t r;
		int pick;
		pick     = $urandom_range(0, 99);
		r.tag    = 8'($urandom);
		r.delay  = random_ticks(20);
		r.period = random_ticks(30);
		r.slot   = 3'($urandom);
		if (pick < 30)
			r.mode = MODE_ADD;
		else if (pick < 42)
			r.mode = MODE_DEL;
		else if (pick < 72)
			r.mode = MODE_TICK;
		else
			r.mode = MODE_DISP;
		return r;
	endfunction

	// Offer one request, after an optional idle burst, and wait for its transfer.
	task automatic send_request(sched_request_t r, bit may_idle);
		if (may_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= r.mode;
		task_tag      <= r.tag;
		start_delay   <= r.delay;
		repeat_period <= r.period;
		slot          <= r.slot;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Stop offering and wait for every outstanding result.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: nothing to dispatch, tick with no tasks.
		send_request(req(MODE_DISP, 8'h00, 16'd0, 16'd0, 3'd0), 1'b1);
		send_request(req(MODE_TICK, 8'h00, 16'd0, 16'd0, 3'd0), 1'b1);
		// Fill all eight slots: one-shots, all-ones delay and period, short periods.
		send_request(req(MODE_ADD, 8'hFF, 16'd0, 16'd0, 3'd0), 1'b1);
		send_request(req(MODE_ADD, 8'h00, 16'hFFFF, 16'hFFFF, 3'd7), 1'b1);
		send_request(req(MODE_ADD, 8'h5A, 16'd1, 16'd2, 3'd0), 1'b1);
		send_request(req(MODE_ADD, 8'h3C, 16'd0, 16'd1, 3'd0), 1'b1);
		send_request(req(MODE_ADD, 8'hC3, 16'd2, 16'd0, 3'd0), 1'b1);
		send_request(req(MODE_ADD, 8'h81, 16'd0, 16'd3, 3'd0), 1'b1);
		send_request(req(MODE_ADD, 8'h7E, 16'd1, 16'd1, 3'd0), 1'b1);
		send_request(req(MODE_ADD, 8'h18, 16'd0, 16'd0, 3'd0), 1'b1);
		// Table full.
		send_request(req(MODE_ADD, 8'h42, 16'd3, 16'd3, 3'd0), 1'b1);
		// After the third tick the one-shots are ready with zero delay.
		send_request(req(MODE_TICK, 8'h00, 16'd0, 16'd0, 3'd0), 1'b1);
		send_request(req(MODE_TICK, 8'h00, 16'd0, 16'd0, 3'd0), 1'b1);
		send_request(req(MODE_TICK, 8'h00, 16'd0, 16'd0, 3'd0), 1'b1);
		// Dispatch with many ready tasks; one-shots are freed.
		send_request(req(MODE_DISP, 8'h00, 16'd0, 16'd0, 3'd0), 1'b1);
		// Delete a used slot, a freed slot, and the same slot twice.
		send_request(req(MODE_DEL, 8'h00, 16'd0, 16'd0, 3'd1), 1'b1);
		send_request(req(MODE_DEL, 8'h00, 16'd0, 16'd0, 3'd0), 1'b1);
		send_request(req(MODE_DEL, 8'h00, 16'd0, 16'd0, 3'd1), 1'b1);
		// Add goes to the lowest free slot.
		send_request(req(MODE_ADD, 8'h99, 16'd0, 16'd5, 3'd0), 1'b1);
		send_request(req(MODE_TICK, 8'h00, 16'd0, 16'd0, 3'd0), 1'b1);
		send_request(req(MODE_DISP, 8'h00, 16'd0, 16'd0, 3'd0), 1'b1);
		send_request(req(MODE_DEL, 8'h00, 16'd0, 16'd0, 3'd7), 1'b1);
		send_request(req(MODE_DEL, 8'h00, 16'd0, 16'd0, 3'd4), 1'b1);
		// A second dispatch with no tick between finds nothing ready.
		send_request(req(MODE_DISP, 8'h00, 16'd0, 16'd0, 3'd0), 1'b1);
		drain();

		// Random traffic in stretches with and without sender idling.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 60)
				hold_req <= 1'b1;
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				calm <= 1'b1;
			send_request(random_request(),
				(i % 24 >= 8) && (i < RANDOM_ITEMS - CALM_ITEMS));
			if (i == 120)
				drain();
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

### tick_task_scheduler.f
+incdir+rtl
rtl/tts_pkg.sv
rtl/tts_slot_mem.sv
rtl/tts_ctrl.sv
rtl/tick_task_scheduler.sv
rtl/tts_checker.sv
verif/tts_checker.sv
verif/tb_top.sv
